/* src/assert_macros.svh */
// assertion macros shared by the utf-8 checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define U8VP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("u8vp assertion failed");
// same with a caller message
`define U8VP_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define U8VP_ASSERT(label, prop)
`define U8VP_ASSERT_MSG(label, prop, msg)
`endif
`endif

/* src/u8vp_pkg.sv */
// shared types and constants of the utf-8 checker and packer
`default_nettype none
package u8vp_pkg;

  // width of the internal character counter
  localparam int COUNT_BITS = 16;
  // width used to saturate the counter onto the 16-bit result field
  localparam int CNT_EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [15:0] CHAR_COUNT_MAX = 16'hffff;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_BAD = 2'd2
  } kind_t;

  // one result from the decode step
  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [31:0] word;
    logic [2:0]  len;
    logic [15:0] count;
  } step_res_t;

endpackage
`default_nettype wire

/* src/u8vp_skid.sv */
// input byte register with a skid entry so stall is registered
`default_nettype none
module u8vp_skid (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_stall,
  input  wire logic       consume,
  output logic            main_valid,
  output logic [7:0]      main_byte
);
  import u8vp_pkg::*;

  logic       main_valid_r, main_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic [7:0] main_byte_r, main_byte_nxt;
  logic [7:0] skid_byte_r, skid_byte_nxt;
  logic       take;

  assign take       = in_valid && !skid_valid_r;
  assign in_stall   = skid_valid_r;
  assign main_valid = main_valid_r;
  assign main_byte  = main_byte_r;

  // next state of the two entries
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_byte_nxt  = main_byte_r;
    skid_byte_nxt  = skid_byte_r;
    if (consume) begin
      if (skid_valid_r) begin
        main_byte_nxt  = skid_byte_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = take;
        main_byte_nxt  = in_byte;
      end
    end else if (!main_valid_r) begin
      main_valid_nxt = take;
      main_byte_nxt  = in_byte;
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_byte_nxt  = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_byte_r <= main_byte_nxt;
    skid_byte_r <= skid_byte_nxt;
  end

`include "assert_macros.svh"
  // the skid entry only fills behind a held main entry
  `U8VP_ASSERT(a_skid_behind_main, skid_valid_r |-> main_valid_r)
  // a full skid is drained before anything new is taken
  `U8VP_ASSERT(a_skid_drain, (skid_valid_r && consume) |=> !skid_valid_r)

endmodule
`default_nettype wire

/* src/u8vp_step.sv */
// per-byte decode step with the character assembly state
`default_nettype none
module u8vp_step (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       byte_in,
  output u8vp_pkg::step_res_t   res
);
  import u8vp_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [1:0]            bytes_left_r, bytes_left_nxt;
  logic [2:0]            byte_total_r, byte_total_nxt;
  logic [23:0]           partial_word_r, partial_word_nxt;
  logic                  error_seen_r, error_seen_nxt;
  logic [COUNT_BITS-1:0] chars_done_r, chars_done_nxt;
  logic [COUNT_BITS-1:0] chars_inc;
  logic [CNT_EXT_W-1:0]  count_ext;
  logic [15:0]           count_sat;

  // saturating counter step and its 16-bit view
  assign chars_inc = (chars_done_r == CNT_MAX) ? chars_done_r : chars_done_r + 1'b1;
  assign count_ext = CNT_EXT_W'(chars_done_r);
  assign count_sat = (count_ext > CNT_EXT_W'(CHAR_COUNT_MAX)) ? CHAR_COUNT_MAX
                                                              : count_ext[15:0];

  // decode one byte
  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    byte_total_nxt   = byte_total_r;
    partial_word_nxt = partial_word_r;
    error_seen_nxt   = error_seen_r;
    chars_done_nxt   = chars_done_r;
    res.emit  = 1'b0;
    res.kind  = KIND_CHAR;
    res.word  = '0;
    res.len   = '0;
    res.count = '0;
    if (fire) begin
      priority if (byte_in == 8'h00) begin
        // terminator: end result, then back to reset state
        res.emit         = 1'b1;
        res.kind         = (error_seen_r || bytes_left_r != 2'd0) ? KIND_END_BAD
                                                                  : KIND_END_OK;
        res.count        = count_sat;
        bytes_left_nxt   = '0;
        byte_total_nxt   = '0;
        partial_word_nxt = '0;
        error_seen_nxt   = 1'b0;
        chars_done_nxt   = '0;
      end else if (error_seen_r) begin
        // skip until terminator
      end else if (bytes_left_r == 2'd0) begin
        priority if (!byte_in[7]) begin
          res.emit       = 1'b1;
          res.word       = {24'h0, byte_in};
          res.len        = 3'd1;
          chars_done_nxt = chars_inc;
        end else if (byte_in[7:5] == 3'b110) begin
          byte_total_nxt   = 3'd2;
          bytes_left_nxt   = 2'd1;
          partial_word_nxt = {16'h0, byte_in};
        end else if (byte_in[7:4] == 4'b1110) begin
          byte_total_nxt   = 3'd3;
          bytes_left_nxt   = 2'd2;
          partial_word_nxt = {16'h0, byte_in};
        end else if (byte_in[7:3] == 5'b11110) begin
          byte_total_nxt   = 3'd4;
          bytes_left_nxt   = 2'd3;
          partial_word_nxt = {16'h0, byte_in};
        end else begin
          // bad lead byte
          error_seen_nxt   = 1'b1;
          bytes_left_nxt   = '0;
          byte_total_nxt   = '0;
          partial_word_nxt = '0;
        end
      end else if (byte_in[7:6] != 2'b10) begin
        // missing continuation
        error_seen_nxt   = 1'b1;
        bytes_left_nxt   = '0;
        byte_total_nxt   = '0;
        partial_word_nxt = '0;
      end else if (bytes_left_r == 2'd1) begin
        // last continuation completes the character
        res.emit         = 1'b1;
        res.word         = {partial_word_r, byte_in};
        res.len          = byte_total_r;
        chars_done_nxt   = chars_inc;
        bytes_left_nxt   = '0;
        byte_total_nxt   = '0;
        partial_word_nxt = '0;
      end else begin
        partial_word_nxt = {partial_word_r[15:0], byte_in};
        bytes_left_nxt   = bytes_left_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= '0;
      byte_total_r   <= '0;
      partial_word_r <= '0;
      error_seen_r   <= 1'b0;
      chars_done_r   <= '0;
    end else begin
      bytes_left_r   <= bytes_left_nxt;
      byte_total_r   <= byte_total_nxt;
      partial_word_r <= partial_word_nxt;
      error_seen_r   <= error_seen_nxt;
      chars_done_r   <= chars_done_nxt;
    end
  end

`include "assert_macros.svh"
  // open character always leaves fewer bytes than its length
  `U8VP_ASSERT_MSG(a_left_below_total, (bytes_left_r != 2'd0) |-> (byte_total_r > 3'(bytes_left_r)), "u8vp bytes_left out of step with byte_total")
  // terminator clears counter and error flag
  `U8VP_ASSERT(a_term_clears, (fire && byte_in == 8'h00) |=> (chars_done_r == '0 && !error_seen_r))

endmodule
`default_nettype wire

/* src/utf8_validate_and_pack_unit.sv */
// Structural UTF-8 checker and packer, one byte accepted per cycle while in_stall is low.
// A byte taken is held in the input register, then decoded into the result register.
// Throughput: one byte per clock sustained while out_stall is low; the decode step is
// combinational logic between the input register and the result register.
// Reset (rst_n low, synchronous) clears character state, counter and both
// handshake stages.
`default_nettype none
module utf8_validate_and_pack_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_char_word,
  output logic [2:0]       out_char_len,
  output logic [15:0]      out_char_count
);
  import u8vp_pkg::*;

  logic        main_valid;
  logic [7:0]  main_byte;
  logic        out_free;
  logic        consume;
  step_res_t   res;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_len_r;
  logic [15:0] out_count_r;

  // result register can take a new request
  assign out_free = !out_valid_r || !out_stall;
  assign consume  = main_valid && out_free;

  u8vp_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .consume    (consume),
    .main_valid (main_valid),
    .main_byte  (main_byte)
  );

  u8vp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (consume),
    .byte_in (main_byte),
    .res     (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = consume && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (consume && res.emit) begin
      out_kind_r  <= res.kind;
      out_word_r  <= res.word;
      out_len_r   <= res.len;
      out_count_r <= res.count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_char_word  = out_word_r;
  assign out_char_len   = out_len_r;
  assign out_char_count = out_count_r;

endmodule
`default_nettype wire

/* test/utf8_validate_and_pack_unit_tb.sv */
// self-checking testbench for the utf-8 checker and packer: directed table, random strings
module utf8_validate_and_pack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8vp_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 350;
  localparam int DIR_N         = 24;
  localparam int SHOWN_ERRORS  = 10;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [2:0]  len;
    logic [15:0] count;
  } char_result_t;

  // one row of the directed table; fixed rows carry their own expected result
  typedef struct packed {
    logic [7:0]   b;
    logic         fixed;
    logic         gives;
    char_result_t res;
  } stim_row_t;

  typedef enum logic [1:0] {
    DMG_INSERT,
    DMG_DROP,
    DMG_REPLACE,
    DMG_NOISE
  } damage_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [31:0] out_char_word;
  logic [2:0]  out_char_len;
  logic [15:0] out_char_count;

  // decoder state kept by the testbench
  logic [1:0]            seq_left;
  logic [2:0]            seq_len;
  logic [23:0]           seq_bytes;
  logic                  str_bad;
  logic [COUNT_BITS-1:0] str_chars;

  char_result_t pending_results[$];
  stim_row_t    dir_rows [DIR_N];

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int bytes_sent;
  int mismatches;
  int quiet_cycles;
  int chars_seen;
  int ends_ok_seen;
  int ends_bad_seen;

  utf8_validate_and_pack_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_char_word  (out_char_word),
    .out_char_len   (out_char_len),
    .out_char_count (out_char_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predict the result of one accepted byte and advance the decoder state
  function automatic void decode_byte(input logic [7:0] b, output bit gives,
                                      output char_result_t r);
    int lead_len;
    gives = 1'b0;
    r = '0;
    if (b == 8'h00) begin
      gives = 1'b1;
      r.kind = (str_bad || seq_left != 2'd0) ? KIND_END_BAD : KIND_END_OK;
      r.count = (str_chars > CHAR_COUNT_MAX) ? CHAR_COUNT_MAX : 16'(str_chars);
      seq_left = '0;
      seq_len = '0;
      seq_bytes = '0;
      str_bad = 1'b0;
      str_chars = '0;
    end else if (!str_bad) begin
      if (seq_left == 2'd0) begin
        casez (b)
          8'b0???????: lead_len = 1;
          8'b110?????: lead_len = 2;
          8'b1110????: lead_len = 3;
          8'b11110???: lead_len = 4;
          default:     lead_len = 0;
        endcase
        if (lead_len == 0) begin
          // continuation or 11111xxx where a lead is expected
          str_bad = 1'b1;
          seq_bytes = '0;
          seq_len = '0;
        end else if (lead_len == 1) begin
          if (str_chars != '1) str_chars++;
          gives = 1'b1;
          r.kind = KIND_CHAR;
          r.word = {24'h0, b};
          r.len = 3'd1;
        end else begin
          seq_len = 3'(lead_len);
          seq_left = 2'(lead_len - 1);
          seq_bytes = {16'h0, b};
        end
      end else if (b[7:6] != 2'b10) begin
        // missing continuation
        str_bad = 1'b1;
        seq_left = '0;
        seq_len = '0;
        seq_bytes = '0;
      end else if (seq_left == 2'd1) begin
        if (str_chars != '1) str_chars++;
        gives = 1'b1;
        r.kind = KIND_CHAR;
        r.word = {seq_bytes, b};
        r.len = seq_len;
        seq_left = '0;
        seq_len = '0;
        seq_bytes = '0;
      end else begin
        seq_bytes = {seq_bytes[15:0], b};
        seq_left = seq_left - 2'd1;
      end
    end
  endfunction

  // offer one request until taken, then log its expected result
  task automatic offer_byte(input logic [7:0] b, input bit fixed, input bit fixed_gives,
                            input char_result_t fixed_res);
    bit           gives;
    char_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, gives, r);
    if (fixed) begin
      gives = fixed_gives;
      r = fixed_res;
    end
    if (gives) pending_results.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // build one string of random characters, optionally damaged, and send it
  task automatic send_string(input int n_chars, input bit broken);
    logic [7:0] seq[$];
    int         len;
    damage_t    dmg;
    seq = {};
    repeat (n_chars) begin
      len = $urandom_range(1, 4);
      case (len)
        1: seq.push_back(8'($urandom_range(1, 127)));
        2: seq.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        3: seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
        default: seq.push_back(8'hf0 | 8'($urandom_range(0, 7)));
      endcase
      repeat (len - 1) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
    if (broken) begin
      dmg = damage_t'($urandom_range(0, 3));
      case (dmg)
        DMG_INSERT: seq.insert($urandom_range(0, seq.size()), 8'($urandom_range(1, 255)));
        DMG_DROP: begin
          if (seq.size() > 0) seq.delete($urandom_range(0, seq.size() - 1));
        end
        DMG_REPLACE: begin
          if (seq.size() > 0) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(1, 255));
        end
        default: begin
          seq = {};
          repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
    seq.push_back(8'h00);
    foreach (seq[i]) offer_byte(seq[i], 1'b0, 1'b0, '0);
  endtask

  // one phase of random strings under a given idle and stall mix
  task automatic run_phase(input int send_idle, input int recv_stall, input bit do_hold,
                           input bit do_pause);
    int start;
    bit mid_done;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    start = bytes_sent;
    mid_done = 1'b0;
    while (bytes_sent - start < PHASE_BYTES) begin
      if (!mid_done && bytes_sent - start >= PHASE_BYTES / 2) begin
        mid_done = 1'b1;
        if (do_pause) drain();
        if (do_hold) begin
          // receiver holds off while the sender keeps offering
          hold_req = 1'b1;
          repeat (4) send_string($urandom_range(4, 10), 1'b0);
        end
      end
      send_string($urandom_range(0, 10), $urandom_range(0, 99) < 20);
    end
    drain();
  endtask

  // receiver stall, with a long hold-off on request
  initial begin : stall_drive
    bit want_hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      want_hold = hold_req;
      @(negedge clk);
      if (want_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    char_result_t want;
    char_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = kind_t'(out_kind);
      got.word = out_char_word;
      got.len = out_char_len;
      got.count = out_char_count;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("[%0t] unexpected result: kind %0d word %h len %0d count %0d",
                   $realtime, out_kind, out_char_word, out_char_len, out_char_count);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.word !== want.word ||
            got.len !== want.len || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("[%0t] mismatch: want kind %0d word %h len %0d count %0d, got %0d %h %0d %0d",
                     $realtime, want.kind, want.word, want.len, want.count,
                     out_kind, out_char_word, out_char_len, out_char_count);
        end
      end
      case (out_kind)
        KIND_CHAR:   chars_seen++;
        KIND_END_OK: ends_ok_seen++;
        default:     ends_bad_seen++;
      endcase
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("utf8_validate_and_pack_unit_tb: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    chars_seen = 0;
    ends_ok_seen = 0;
    ends_bad_seen = 0;
    seq_left = '0;
    seq_len = '0;
    seq_bytes = '0;
    str_bad = 1'b0;
    str_chars = '0;
    dir_rows = '{
      // empty string right after reset
      '{8'h00, 1'b1, 1'b1, '{KIND_END_OK,  32'h0,        3'd0, 16'd0}},
      // one-byte characters, up to the top value 7f
      '{8'h41, 1'b1, 1'b1, '{KIND_CHAR,    32'h41,       3'd1, 16'd0}},
      '{8'h7f, 1'b1, 1'b1, '{KIND_CHAR,    32'h7f,       3'd1, 16'd0}},
      // two-byte character
      '{8'hc3, 1'b1, 1'b0, '0},
      '{8'ha9, 1'b1, 1'b1, '{KIND_CHAR,    32'hc3a9,     3'd2, 16'd0}},
      // three- and four-byte characters
      '{8'he2, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'hac, 1'b0, 1'b0, '0},
      '{8'hf4, 1'b0, 1'b0, '0},
      '{8'h8f, 1'b0, 1'b0, '0},
      '{8'hbf, 1'b0, 1'b0, '0},
      '{8'hbf, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_END_OK,  32'h0,        3'd0, 16'd5}},
      // bad lead, then a byte skipped after the error
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'h41, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_END_BAD, 32'h0,        3'd0, 16'd0}},
      // 11111xxx lead
      '{8'hff, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_END_BAD, 32'h0,        3'd0, 16'd0}},
      // missing continuation
      '{8'hc2, 1'b0, 1'b0, '0},
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_END_BAD, 32'h0,        3'd0, 16'd0}},
      // truncated sequence after one good character
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'he2, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_END_BAD, 32'h0,        3'd0, 16'd1}}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) offer_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].gives,
                                     dir_rows[i].res);
    drain();

    // random strings under each idle and stall mix
    run_phase(0, 0, 1'b1, 1'b0);
    run_phase(54, 0, 1'b0, 1'b1);
    run_phase(0, 54, 1'b0, 1'b0);
    run_phase(15, 15, 1'b0, 1'b1);

    $display("covered %0d bytes: %0d characters, %0d good and %0d bad string ends",
             bytes_sent, chars_seen, ends_ok_seen, ends_bad_seen);
    $display("directed cases, damaged strings, receiver hold-off and sender drain pauses run");
    if (mismatches == 0)
      $display("utf8_validate_and_pack_unit_tb: done, clean");
    else
      $display("utf8_validate_and_pack_unit_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/u8vp_pkg.sv
src/u8vp_skid.sv
src/u8vp_step.sv
src/utf8_validate_and_pack_unit.sv
test/utf8_validate_and_pack_unit_tb.sv
